// ===== hw/rtl/expiry_ordered_timer_queue_macros.svh =====
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef EXPIRY_ORDERED_TIMER_QUEUE_MACROS_SVH
`define EXPIRY_ORDERED_TIMER_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define EOTQ_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);
// Implication checked in the cycle after the condition.
`define EOTQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== hw/rtl/eotq_pkg.sv =====
// Package of the timer queue: operation and status codes, and width constants.
// Depends on nothing.
package eotq_pkg;
  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SCHEDULED   = 2'd1,
    ST_NOT_SCHED   = 2'd2,
    ST_NONE_DUE    = 2'd3
  } status_t;

  localparam int unsigned SLOT_W = 5;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MAX_OUT = 32;
endpackage

// ===== hw/rtl/expiry_ordered_timer_queue.sv =====
// Top level of the expiry-ordered timer queue: a sorted list kept in memory.
// Depends on eotq_pkg and expiry_ordered_timer_queue_macros.svh.
//
// A word is taken when start is high and busy is low. Results appear for one
// cycle each with strobe high; the receiver cannot stall them, so the block
// never waits on it. Scheduled slots are held in one sorted list memory
// (order), each entry carrying the slot number together with its expiry, so
// that one registered read gives both. A register walks the list from the
// head, one entry at a time (address, then compare on the registered read),
// and then shifts the tail up one entry at a time (address, then write); a
// cancel walks to the slot and shifts the tail down. A tick reads the head,
// compares, and on expiry removes it by a tail shift. The result of an
// expired slot is held back until the next head has been compared, so that
// the final result of the run can be marked with last_of_run. A tick with
// nothing due registers its one result in S_RADDR when the list is empty,
// else in S_RCHK after the head has been compared.
// Busy falls in the cycle in which the last result of a word is shown, so
// the next word can be taken at the edge that ends that cycle.
// Slot numbers at or above SLOTS are answered with status "not scheduled".
module expiry_ordered_timer_queue
  import eotq_pkg::*;
#(
  parameter int unsigned SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op,
  input  logic [4:0]        slot_id,
  input  logic [31:0]       expire_time,
  input  logic [31:0]       now_time,
  output logic              strobe,
  output logic [4:0]        expired_slot,
  output logic [1:0]        status,
  output logic              last_of_run
);
`include "expiry_ordered_timer_queue_macros.svh"

  // Slot numbers come in on five bits, so no more than that is ever indexed.
  localparam int unsigned IW = (SLOTS > 32) ? SLOT_W : ((SLOTS > 1) ? $clog2(SLOTS) : 1);
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = TIME_W + IW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RADDR  = 9'b000000010,
    S_RCHK   = 9'b000000100,
    S_UPADDR = 9'b000001000,
    S_UPWR   = 9'b000010000,
    S_DNADDR = 9'b000100000,
    S_DNWR   = 9'b001000000,
    S_DONE   = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  // Memory: sorted list of {expiry, slot} entries.
  logic [EW-1:0]     order_mem [SLOTS];
  logic              sched [SLOTS];

  state_t            state;
  logic [1:0]        cur_op;
  logic [IW-1:0]     cur_slot;
  logic [31:0]       cur_time;
  logic [CW-1:0]     count;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     ptr;
  logic [5:0]        emitted;
  logic [EW-1:0]     rd_entry;
  logic [IW-1:0]     rd_slot;
  logic [TIME_W-1:0] rd_exp;
  logic [IW-1:0]     ord_addr;
  logic              ord_we;
  logic [IW-1:0]     ord_waddr;
  logic [EW-1:0]     ord_wdata;

  // Registered read of the list; slot and expiry come out together.
  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    rd_entry <= order_mem[ord_addr];
  end

  assign rd_slot = rd_entry[IW-1:0];
  assign rd_exp  = rd_entry[EW-1:IW];

  logic valid_slot;
  assign valid_slot = ({27'd0, slot_id} < SLOTS);
  assign busy = (state != S_IDLE);

  // Ordering of the new entry against a read entry.
  logic new_first;
  always_comb begin
    if (cur_time != rd_exp) begin
      new_first = cur_time < rd_exp;
    end else begin
      new_first = cur_slot < rd_slot;
    end
  end

  always_comb begin
    ord_addr  = '0;
    ord_we    = 1'b0;
    ord_waddr = '0;
    ord_wdata = '0;
    case (state)
      S_RADDR: begin
        ord_addr = pos[IW-1:0];
      end
      S_UPADDR: begin
        ord_addr = IW'(ptr - 1'b1);
      end
      S_UPWR: begin
        ord_we    = 1'b1;
        ord_waddr = ptr[IW-1:0];
        ord_wdata = rd_entry;
      end
      S_DNADDR: begin
        ord_addr = IW'(ptr + 1'b1);
      end
      S_DNWR: begin
        ord_we    = 1'b1;
        ord_waddr = ptr[IW-1:0];
        ord_wdata = rd_entry;
      end
      S_DONE: begin
        if (cur_op == OP_REGISTER) begin
          ord_we    = 1'b1;
          ord_waddr = pos[IW-1:0];
          ord_wdata = {cur_time, cur_slot};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      strobe  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        sched[i] <= 1'b0;
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_op   <= op;
            cur_slot <= slot_id[IW-1:0];
            pos      <= '0;
            emitted  <= '0;
            expired_slot <= slot_id;
            last_of_run  <= 1'b1;
            case (op)
              OP_REGISTER: begin
                cur_time <= expire_time;
                if (!valid_slot) begin
                  status <= ST_NOT_SCHED;
                  state  <= S_RESULT;
                end else if (sched[slot_id[IW-1:0]]) begin
                  status <= ST_SCHEDULED;
                  state  <= S_RESULT;
                end else begin
                  status <= ST_OK;
                  sched[slot_id[IW-1:0]] <= 1'b1;
                  state  <= S_RADDR;
                end
              end
              OP_CANCEL: begin
                if (!valid_slot || !sched[slot_id[IW-1:0]]) begin
                  status <= ST_NOT_SCHED;
                  state  <= S_RESULT;
                end else begin
                  status <= ST_OK;
                  sched[slot_id[IW-1:0]] <= 1'b0;
                  state  <= S_RADDR;
                end
              end
              OP_TICK: begin
                cur_time <= now_time;
                state    <= S_RADDR;
              end
              default: begin
              end
            endcase
          end
        end
        S_RADDR: begin
          if (pos >= count) begin
            if (cur_op == OP_REGISTER) begin
              ptr   <= count;
              state <= S_UPADDR;
            end else if (cur_op == OP_TICK) begin
              // List empty: show the held slot as the last one, or report none due.
              if (emitted == 6'd0) begin
                expired_slot <= '0;
                status       <= ST_NONE_DUE;
              end
              last_of_run <= 1'b1;
              strobe      <= 1'b1;
              state       <= S_IDLE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_RCHK;
          end
        end
        S_RCHK: begin
          case (cur_op)
            OP_REGISTER: begin
              if (new_first) begin
                ptr   <= count;
                state <= S_UPADDR;
              end else begin
                pos   <= pos + 1'b1;
                state <= S_RADDR;
              end
            end
            OP_CANCEL: begin
              if (rd_slot == cur_slot) begin
                ptr   <= pos;
                state <= S_DNADDR;
              end else begin
                pos   <= pos + 1'b1;
                state <= S_RADDR;
              end
            end
            default: begin
              // Tick: head at pos zero.
              if (rd_exp <= cur_time && emitted < 6'(MAX_OUT)) begin
                // Another slot is due, so the held one is not the last.
                if (emitted != 6'd0) begin
                  last_of_run <= 1'b0;
                  strobe      <= 1'b1;
                end
                sched[rd_slot] <= 1'b0;
                cur_slot <= rd_slot;
                ptr      <= '0;
                state    <= S_DNADDR;
              end else begin
                if (emitted == 6'd0) begin
                  expired_slot <= '0;
                  status       <= ST_NONE_DUE;
                end
                last_of_run <= 1'b1;
                strobe      <= 1'b1;
                state       <= S_IDLE;
              end
            end
          endcase
        end
        S_UPADDR: begin
          if (ptr == pos) begin
            state <= S_DONE;
          end else begin
            state <= S_UPWR;
          end
        end
        S_UPWR: begin
          ptr   <= ptr - 1'b1;
          state <= S_UPADDR;
        end
        S_DNADDR: begin
          if (ptr + 1'b1 >= count) begin
            state <= S_DONE;
          end else begin
            state <= S_DNWR;
          end
        end
        S_DNWR: begin
          ptr   <= ptr + 1'b1;
          state <= S_DNADDR;
        end
        S_DONE: begin
          if (cur_op == OP_REGISTER) begin
            count <= count + 1'b1;
            state <= S_RESULT;
          end else if (cur_op == OP_CANCEL) begin
            count <= count - 1'b1;
            state <= S_RESULT;
          end else begin
            // Tick: hold this slot's result, then test the new head.
            count        <= count - 1'b1;
            emitted      <= emitted + 1'b1;
            expired_slot <= 5'(cur_slot);
            status       <= ST_OK;
            pos          <= '0;
            state        <= S_RADDR;
          end
        end
        S_RESULT: begin
          strobe <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `EOTQ_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(SLOTS), "count over depth")
  `EOTQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy && op != OP_NONE, busy, "no busy")
  `EOTQ_ASSERT_IMPLY(a_strobe_idle, clk, rst, strobe && last_of_run, !busy, "late result")
endmodule
